// ----- sv/kdf_pkg.sv -----
// Shared types, codes and CRC helpers for the KISS deframer with FCS.
// No dependencies; used by every module of the block.
package kdf_pkg;

  localparam logic [7:0] FEND     = 8'hC0;
  localparam logic [7:0] FESC     = 8'hDB;
  localparam logic [7:0] TFEND    = 8'hDC;
  localparam logic [7:0] TFESC    = 8'hDD;
  localparam logic [7:0] CMD_DATA = 8'h00;
  localparam logic [7:0] CMD_P    = 8'h01;
  localparam logic [7:0] CMD_SLOT = 8'h03;

  localparam int          LEN_W         = 10;
  localparam logic [9:0]  LEN_MAX       = 10'd1023;
  localparam logic [9:0]  MAX_LEN_RESET = 10'd253;
  localparam logic [15:0] CRC_INIT      = 16'hFFFF;
  localparam int          QUEUE_DEPTH_DEF = 4;

  localparam logic [1:0]  REG_MAX_LEN   = 2'd0;

  typedef enum logic [2:0] {
    ST_VOID,
    ST_CMD,
    ST_P,
    ST_SLOT,
    ST_DATA,
    ST_ESC
  } state_t;

  typedef enum logic [2:0] {
    KIND_PAYLOAD = 3'd0,
    KIND_FCS     = 3'd1,
    KIND_DROP    = 3'd2,
    KIND_PERS    = 3'd3,
    KIND_SLOT    = 3'd4
  } kind_t;

  // One queue entry per input byte that yields output; an FCS entry carries
  // both bytes and is played out over two transfers.
  typedef struct packed {
    kind_t       kind;
    logic [11:0] value;
    logic        last;
    logic        hi_valid;
    logic [7:0]  hi_byte;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [15:0] nib_tab(input logic [3:0] idx);
    logic [15:0] r;
    case (idx)
      4'h0: r = 16'h0000;
      4'h1: r = 16'h1081;
      4'h2: r = 16'h2102;
      4'h3: r = 16'h3183;
      4'h4: r = 16'h4204;
      4'h5: r = 16'h5285;
      4'h6: r = 16'h6306;
      4'h7: r = 16'h7387;
      4'h8: r = 16'h8408;
      4'h9: r = 16'h9489;
      4'hA: r = 16'ha50a;
      4'hB: r = 16'hb58b;
      4'hC: r = 16'hc60c;
      4'hD: r = 16'hd68d;
      4'hE: r = 16'he70e;
      default: r = 16'hf78f;
    endcase
    return r;
  endfunction

  // CRC-16/X.25, reflected, low nibble first.
  function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] t;
    t = (c >> 4) ^ nib_tab(c[3:0] ^ b[3:0]);
    t = (t >> 4) ^ nib_tab(t[3:0] ^ b[7:4]);
    return t;
  endfunction

endpackage

// ----- sv/kdf_parser.sv -----
// Front end: accepts serial bytes, runs the KISS parser, CRC and length count,
// and pushes one entry per output-producing byte. Depends on kdf_pkg.
module kdf_parser (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [7:0]                 in_tdata,
  input  logic [kdf_pkg::LEN_W-1:0]  max_len,
  input  kdf_pkg::q_stat_t           q_stat,
  output logic                       q_push,
  output kdf_pkg::entry_t            q_wdata
);

  kdf_pkg::state_t             state_r, state_nxt;
  logic                        is_data_r, is_data_nxt;
  logic [15:0]                 crc_r, crc_nxt;
  logic [kdf_pkg::LEN_W-1:0]   len_r, len_nxt;
  logic                        in_fire;
  logic [7:0]                  b;
  logic [7:0]                  pay_byte;
  logic [15:0]                 crc_upd;
  logic [kdf_pkg::LEN_W-1:0]   len_inc;
  logic                        esc_ok;
  logic [11:0]                 b_ext;

  assign in_tready = !q_stat.full;
  assign in_fire   = in_tvalid && in_tready;
  assign b         = in_tdata;
  assign b_ext     = {4'b0, b};
  assign esc_ok    = (b == kdf_pkg::TFEND) || (b == kdf_pkg::TFESC);
  assign pay_byte  = (state_r == kdf_pkg::ST_ESC) ?
                     ((b == kdf_pkg::TFEND) ? kdf_pkg::FEND : kdf_pkg::FESC) : b;
  assign crc_upd   = kdf_pkg::crc_byte(crc_r, pay_byte);
  assign len_inc   = (len_r == kdf_pkg::LEN_MAX) ? len_r : len_r + 1'b1;

  // next state
  always_comb begin
    state_nxt   = state_r;
    is_data_nxt = is_data_r;
    crc_nxt     = crc_r;
    len_nxt     = len_r;
    if (in_fire) begin
      case (state_r)
        kdf_pkg::ST_VOID: begin
          if (b == kdf_pkg::FEND) begin
            is_data_nxt = 1'b0;
            state_nxt   = kdf_pkg::ST_CMD;
          end
        end
        kdf_pkg::ST_CMD: begin
          if (b != kdf_pkg::FEND) begin
            if (b == kdf_pkg::CMD_DATA) begin
              is_data_nxt = 1'b1;
              state_nxt   = kdf_pkg::ST_DATA;
              crc_nxt     = kdf_pkg::CRC_INIT;
              len_nxt     = '0;
            end else if (b == kdf_pkg::CMD_P) begin
              is_data_nxt = 1'b0;
              state_nxt   = kdf_pkg::ST_P;
            end else if (b == kdf_pkg::CMD_SLOT) begin
              is_data_nxt = 1'b0;
              state_nxt   = kdf_pkg::ST_SLOT;
            end else begin
              is_data_nxt = 1'b0;
              state_nxt   = kdf_pkg::ST_VOID;
            end
          end
        end
        kdf_pkg::ST_P, kdf_pkg::ST_SLOT: begin
          state_nxt = kdf_pkg::ST_DATA;
        end
        kdf_pkg::ST_DATA: begin
          if (b == kdf_pkg::FESC) begin
            state_nxt = kdf_pkg::ST_ESC;
          end else if (b == kdf_pkg::FEND) begin
            if (is_data_r) begin
              crc_nxt = kdf_pkg::CRC_INIT;
              len_nxt = '0;
            end
            is_data_nxt = 1'b0;
            state_nxt   = kdf_pkg::ST_VOID;
          end else if (is_data_r) begin
            crc_nxt = crc_upd;
            len_nxt = len_inc;
          end
        end
        kdf_pkg::ST_ESC: begin
          if (esc_ok) begin
            state_nxt = kdf_pkg::ST_DATA;
            if (is_data_r) begin
              crc_nxt = crc_upd;
              len_nxt = len_inc;
            end
          end else begin
            crc_nxt     = kdf_pkg::CRC_INIT;
            len_nxt     = '0;
            is_data_nxt = 1'b0;
            state_nxt   = kdf_pkg::ST_VOID;
          end
        end
        default: begin
          is_data_nxt = 1'b0;
          state_nxt   = kdf_pkg::ST_VOID;
        end
      endcase
    end
  end

  // outputs: queue entry for this byte
  always_comb begin
    q_push           = 1'b0;
    q_wdata.kind     = kdf_pkg::KIND_PAYLOAD;
    q_wdata.value    = {4'b0, pay_byte};
    q_wdata.last     = 1'b0;
    q_wdata.hi_valid = 1'b0;
    q_wdata.hi_byte  = '0;
    case (state_r)
      kdf_pkg::ST_P: begin
        q_push        = in_fire;
        q_wdata.kind  = kdf_pkg::KIND_PERS;
        q_wdata.value = b_ext;
      end
      kdf_pkg::ST_SLOT: begin
        q_push        = in_fire;
        q_wdata.kind  = kdf_pkg::KIND_SLOT;
        q_wdata.value = (b_ext << 3) + (b_ext << 1);
      end
      kdf_pkg::ST_DATA: begin
        if (b == kdf_pkg::FEND) begin
          q_push = in_fire && is_data_r;
          if (len_r > max_len) begin
            q_wdata.kind  = kdf_pkg::KIND_DROP;
            q_wdata.value = '0;
            q_wdata.last  = 1'b1;
          end else begin
            q_wdata.kind     = kdf_pkg::KIND_FCS;
            q_wdata.value    = {4'b0, ~crc_r[7:0]};
            q_wdata.hi_valid = 1'b1;
            q_wdata.hi_byte  = ~crc_r[15:8];
          end
        end else if (b != kdf_pkg::FESC) begin
          q_push = in_fire && is_data_r;
        end
      end
      kdf_pkg::ST_ESC: begin
        q_push = in_fire && is_data_r;
        if (!esc_ok) begin
          q_wdata.kind  = kdf_pkg::KIND_DROP;
          q_wdata.value = '0;
          q_wdata.last  = 1'b1;
        end
      end
      default: begin
        q_push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= kdf_pkg::ST_VOID;
      is_data_r <= 1'b0;
      crc_r     <= kdf_pkg::CRC_INIT;
      len_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      is_data_r <= is_data_nxt;
      crc_r     <= crc_nxt;
      len_r     <= len_nxt;
    end
  end

endmodule

// ----- sv/kdf_queue.sv -----
// Short FIFO of parser entries between front and back end.
// Depends on kdf_pkg for the entry and status types.
module kdf_queue #(
  parameter int DEPTH = kdf_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  kdf_pkg::entry_t   wdata,
  input  logic              pop,
  output kdf_pkg::entry_t   rdata,
  output kdf_pkg::q_stat_t  stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  kdf_pkg::entry_t    mem_r [DEPTH];
  logic [PTR_W-1:0]   wptr_r, wptr_nxt;
  logic [PTR_W-1:0]   rptr_r, rptr_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               do_push, do_pop;

  assign stat.full  = (cnt_r == CNT_W'(DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign rdata      = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == PTR_W'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == PTR_W'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

endmodule

// ----- sv/kdf_emitter.sv -----
// Back end: pops queue entries into the output register, splitting an FCS
// entry into its low and high byte transfers. Depends on kdf_pkg.
module kdf_emitter (
  input  logic              clk,
  input  logic              rst_n,
  input  kdf_pkg::entry_t   q_rdata,
  input  kdf_pkg::q_stat_t  q_stat,
  output logic              q_pop,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [15:0]       out_tdata,
  output logic [2:0]        out_tuser,
  output logic              out_tlast
);

  logic            valid_r, valid_nxt;
  kdf_pkg::kind_t  kind_r, kind_nxt;
  logic [11:0]     value_r, value_nxt;
  logic            last_r, last_nxt;
  logic            pend_r, pend_nxt;
  logic [7:0]      hi_r, hi_nxt;
  logic            load;

  assign load  = !valid_r || out_tready;
  assign q_pop = load && !pend_r && !q_stat.empty;

  always_comb begin
    valid_nxt = valid_r;
    kind_nxt  = kind_r;
    value_nxt = value_r;
    last_nxt  = last_r;
    pend_nxt  = pend_r;
    hi_nxt    = hi_r;
    if (load) begin
      if (pend_r) begin
        // second FCS byte closes the frame
        valid_nxt = 1'b1;
        kind_nxt  = kdf_pkg::KIND_FCS;
        value_nxt = {4'b0, hi_r};
        last_nxt  = 1'b1;
        pend_nxt  = 1'b0;
      end else if (!q_stat.empty) begin
        valid_nxt = 1'b1;
        kind_nxt  = q_rdata.kind;
        value_nxt = q_rdata.value;
        last_nxt  = q_rdata.last;
        pend_nxt  = q_rdata.hi_valid;
        hi_nxt    = q_rdata.hi_byte;
      end else begin
        valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      pend_r  <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r  <= kind_nxt;
    value_r <= value_nxt;
    last_r  <= last_nxt;
    hi_r    <= hi_nxt;
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {4'b0, value_r};
  assign out_tuser  = kind_r;
  assign out_tlast  = last_r;

endmodule

// ----- sv/kiss_deframer_with_fcs.sv -----
// KISS deframer with CRC-16/X.25 FCS: takes one serial byte per transfer and
// emits payload bytes cut-through, two FCS bytes (low first) at the closing
// FEND, a drop marker for over-long or badly escaped frames, and the new
// persistence or slot time (x10 ms) for P and SlotTime frames. The input
// side takes one byte every cycle while in_tready is high; each byte is
// parsed in the cycle it is taken and its result waits in a
// QUEUE_DEPTH-entry queue, then in the output register. The output side
// moves one transfer per cycle while out_tready is high, so an FCS frame
// close takes two output transfers; in_tready drops only while that queue
// is full. The max_frame_length register (reset 253) is at every APB address.
// Depends on kdf_pkg, kdf_parser, kdf_queue and kdf_emitter.
module kiss_deframer_with_fcs #(
  parameter int QUEUE_DEPTH = kdf_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,     // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,    // [11:0] value, [15:12] zero
  output logic [2:0]  out_tuser,    // [2:0] kind
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [1:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [kdf_pkg::LEN_W-1:0] max_len_r, max_len_nxt;
  logic                      cfg_wr;
  logic                      q_push, q_pop;
  kdf_pkg::entry_t           q_wdata, q_rdata;
  kdf_pkg::q_stat_t          q_stat;

  // one register; address and byte lanes ignored
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                      (cfg_paddr[1:0] == kdf_pkg::REG_MAX_LEN || 1'b1);
  assign max_len_nxt = cfg_wr ? cfg_pwdata[kdf_pkg::LEN_W-1:0] : max_len_r;
  assign cfg_prdata = {{(32 - kdf_pkg::LEN_W){1'b0}}, max_len_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= kdf_pkg::MAX_LEN_RESET;
    end else begin
      max_len_r <= max_len_nxt;
    end
  end

  kdf_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .max_len   (max_len_r),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  kdf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  kdf_emitter u_emitter (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_rdata    (q_rdata),
    .q_stat     (q_stat),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

`ifndef NO_ASSERTIONS
  // parser never pushes into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_push && q_stat.full))
    else $error("entry pushed into full queue");

  // only FCS and drop transfers may close a frame
  a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |->
      (out_tuser == kdf_pkg::KIND_FCS || out_tuser == kdf_pkg::KIND_DROP))
    else $error("tlast on a non-closing transfer");

  // a taken low FCS byte is followed by the closing high byte
  a_fcs_pair: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tuser == kdf_pkg::KIND_FCS && !out_tlast) |=>
      (out_tvalid && out_tuser == kdf_pkg::KIND_FCS && out_tlast))
    else $error("FCS low byte not followed by high byte");
`endif

endmodule
